### src/spr_pkg.sv
// Shared types, codes and widths of the sequenced packet reassembler.
package spr_pkg;

	localparam int unsigned SPR_BUFFER_DEPTH = 1024;

	localparam int unsigned CAP_W     = 11;
	localparam int unsigned S_DATA_W  = 24;
	localparam int unsigned S_USER_W  = 3;
	localparam int unsigned M_DATA_W  = 48;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned RIDX_W    = 10;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [1:0] {
		REQ_PACKET = 2'd0,
		REQ_CLEAR  = 2'd1,
		REQ_READ   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_CLEAR   = 2'd0,
		ST_INTER   = 2'd1,
		ST_SUCCESS = 2'd2,
		ST_ERROR   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		PH_SEQ     = 5'b00001,
		PH_LEN_LO  = 5'b00010,
		PH_LEN_HI  = 5'b00100,
		PH_DATA    = 5'b01000,
		PH_DISCARD = 5'b10000
	} phase_t;

endpackage

### src/spr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/sequenced_packet_reassembler_core.sv
// Top level of the sequenced packet reassembler: packet parser, message buffer, result stage.
//
//  channel | dir | handshake            | contents
//  s_*     | in  | s_tvalid / s_tready  | one request beat: packet byte, clear or buffer read
//  m_*     | out | m_tvalid / m_tready  | one status beat per request
//  cfg_*   | in  | cfg_we               | capacity register
//
// One request per cycle unless m_tready stalls; each result passes through the registered read
// of the message buffer (the read stage) and then through the output register.
// Parser state updates in the accept cycle, so back-to-back beats see each other's effect.
// Reset clears control state at once; the buffer holds no reset and needs no clearing pass.
// A stall on m_tready holds the output register, then the buffer read stage, then s_tready.
module sequenced_packet_reassembler_core #(
	parameter int unsigned BUFFER_DEPTH = spr_pkg::SPR_BUFFER_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] data_byte, [17:8] read_index, [23:18] zero
	input  logic [spr_pkg::S_DATA_W-1:0]  s_tdata,
	// [1:0] req_type, [2] byte_present
	input  logic [spr_pkg::S_USER_W-1:0]  s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] transfer_status, [9:2] read_byte, [25:10] message_length,
	// [41:26] expected_sequence, [47:42] zero
	output logic [spr_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic [spr_pkg::CAP_W-1:0]     cfg_wdata
);

	import spr_pkg::*;

	localparam int unsigned AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [WORD_W:0] DepthW = (WORD_W+1)'(BUFFER_DEPTH);

	// request fields
	logic [1:0]        req_type;
	logic [BYTE_W-1:0] data_byte;
	logic              byte_present;
	logic              packet_end;
	logic [RIDX_W-1:0] read_index;

	assign req_type     = s_tuser[1:0];
	assign byte_present = s_tuser[2];
	assign data_byte    = s_tdata[7:0];
	assign read_index   = s_tdata[17:8];
	assign packet_end   = s_tlast;

	// parser state
	logic [CAP_W-1:0]  capacity_q;
	status_t           status_q;
	logic [WORD_W-1:0] total_q;
	logic [WORD_W-1:0] fill_q;
	logic [WORD_W-1:0] seq_q;
	phase_t            phase_q;
	logic [BYTE_W-1:0] len_lo_q;

	// pipeline
	logic              s1_valid;
	status_t           status_s1;
	logic [WORD_W-1:0] total_s1;
	logic [WORD_W-1:0] seq_s1;
	logic              rd_s1;
	logic              out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	logic s_accept;
	logic s1_adv;
	logic out_load;

	assign out_load = s1_valid && (!out_valid_q || m_tready);
	assign s1_adv   = !s1_valid || out_load;
	assign s_tready = s1_adv;
	assign s_accept = s_tvalid && s_tready;

	// next-state logic
	status_t           st_c;
	logic [WORD_W-1:0] total_c;
	logic [WORD_W-1:0] fill_c;
	logic [WORD_W-1:0] seq_c;
	phase_t            phase_c;
	logic [BYTE_W-1:0] len_lo_c;
	logic              we_c;
	logic [WORD_W-1:0] waddr_c;
	logic              re_c;
	logic [WORD_W:0]   eff_cap;
	logic [WORD_W-1:0] ridx_ext;

	assign eff_cap  = ({6'd0, capacity_q} < DepthW) ? {6'd0, capacity_q} : DepthW;
	assign ridx_ext = {6'd0, read_index};

	always_comb begin
		st_c     = status_q;
		total_c  = total_q;
		fill_c   = fill_q;
		seq_c    = seq_q;
		phase_c  = phase_q;
		len_lo_c = len_lo_q;
		we_c     = 1'b0;
		waddr_c  = fill_q;
		re_c     = 1'b0;
		case (req_type)
			REQ_PACKET: begin
				if (byte_present) begin
					case (phase_c)
						PH_SEQ: begin
							if (data_byte == 8'd0) begin
								if (seq_c != 16'd0) begin
									st_c = ST_ERROR;
								end
								phase_c = PH_LEN_LO;
							end else if ({8'd0, data_byte} != seq_c) begin
								st_c    = ST_ERROR;
								phase_c = PH_DISCARD;
							end else begin
								phase_c = PH_DATA;
							end
						end
						PH_LEN_LO: begin
							len_lo_c = data_byte;
							phase_c  = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							st_c    = ST_INTER;
							total_c = {data_byte, len_lo_c};
							seq_c   = '0;
							fill_c  = '0;
							if ({1'b0, total_c} > eff_cap) begin
								st_c    = ST_ERROR;
								phase_c = PH_DISCARD;
							end else begin
								phase_c = PH_DATA;
							end
						end
						PH_DATA: begin
							if (fill_c < total_c) begin
								we_c   = ({1'b0, fill_c} < DepthW);
								fill_c = fill_c + 16'd1;
							end
						end
						default: begin
						end
					endcase
				end
				if (packet_end) begin
					case (phase_c)
						PH_SEQ, PH_LEN_LO, PH_LEN_HI: begin
							st_c = ST_ERROR;
						end
						PH_DATA: begin
							if (fill_c == total_c) begin
								st_c = ST_SUCCESS;
							end else begin
								seq_c = seq_c + 16'd1;
							end
						end
						default: begin
						end
					endcase
					phase_c = PH_SEQ;
				end
			end
			REQ_CLEAR: begin
				st_c     = ST_CLEAR;
				total_c  = '0;
				fill_c   = '0;
				seq_c    = '0;
				len_lo_c = '0;
				phase_c  = PH_SEQ;
			end
			REQ_READ: begin
				re_c = ({1'b0, ridx_ext} < DepthW);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			status_q   <= ST_CLEAR;
			total_q    <= '0;
			fill_q     <= '0;
			seq_q      <= '0;
			phase_q    <= PH_SEQ;
			len_lo_q   <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (s_accept) begin
				status_q <= st_c;
				total_q  <= total_c;
				fill_q   <= fill_c;
				seq_q    <= seq_c;
				phase_q  <= phase_c;
				len_lo_q <= len_lo_c;
			end
		end
	end

	// message buffer
	logic              ram_we;
	logic              ram_re;
	logic [BYTE_W-1:0] ram_rdata;

	assign ram_we = s_accept && we_c;
	assign ram_re = s_accept && re_c;

	spr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUFFER_DEPTH),
		.AW    (AddrW)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_c[AddrW-1:0]),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (ridx_ext[AddrW-1:0]),
		.rdata (ram_rdata)
	);

	// read stage: wait for the buffer's registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_adv) begin
			s1_valid <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			status_s1 <= st_c;
			total_s1  <= total_c;
			seq_s1    <= seq_c;
			rd_s1     <= re_c;
		end
	end

	// output register
	logic [BYTE_W-1:0] read_byte;

	assign read_byte = rd_s1 ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'd0, seq_s1, total_s1, read_byte, status_s1};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= total_q)
		else $error("fill offset beyond announced length");

	a_success_full: assert property (@(posedge clk) disable iff (!arst_n)
		status_q == ST_SUCCESS |-> fill_q == total_q)
		else $error("success reported with message incomplete");

	a_write_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> phase_q == PH_DATA && req_type == REQ_PACKET && byte_present)
		else $error("buffer write outside data phase");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> s1_valid && rd_s1)
		else $error("buffer read lost before result stage");
`endif

endmodule
